[src/lagged_difference_filter_defines.svh]
// assertion macros for the lagged difference filter
`ifndef LAGGED_DIFFERENCE_FILTER_DEFINES_SVH
`define LAGGED_DIFFERENCE_FILTER_DEFINES_SVH

// same-cycle implication, checked at every rising edge out of reset
`define LDF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LDF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ldf_pkg.sv]
// shared constants and register codes of the lagged difference filter
`default_nettype none

package ldf_pkg;

  localparam int LDF_MAX_LAG     = 16;
  localparam int LDF_MAX_ORDER   = 4;
  localparam int LDF_SAMPLE_BITS = 16;

  localparam int LAG_REG_W   = 5;
  localparam int ORDER_REG_W = 3;
  localparam int CFG_ADDR_W  = 2;
  localparam int CFG_DATA_W  = 5;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_LAG_DISTANCE     = 2'd0,
    CFG_DIFFERENCE_ORDER = 2'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

[src/ldf_ram.sv]
// generic single-write, single-read ram with registered read data
`default_nettype none

module ldf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [0:DEPTH-1];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word when the same entry is written in that cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[src/lagged_difference_filter.sv]
// Lagged difference filter: order-d differencing with lag L of a signed sample
// stream, one sample per clock unless the output stalls, with a compute stage
// register ahead of the output register. Every stage's delay line sits in one
// history ram of MAX_LAG rows, each row holding the MAX_ORDER stage inputs for one
// ring position; an accepted sample reads its row, the compute stage runs the
// subtraction chain and writes the row back as it advances, and a bypass register
// covers the next sample reading the row being written, as at lag one. A result
// is given once d*L samples of the current series have arrived; a new series
// starts with in_tuser or after a lag or order register write. History is never
// cleared: the warm-up count hides every entry not yet written in the series.
`default_nettype none

module lagged_difference_filter
  import ldf_pkg::*;
#(
  parameter int MAX_LAG     = LDF_MAX_LAG,
  parameter int MAX_ORDER   = LDF_MAX_ORDER,
  parameter int SAMPLE_BITS = LDF_SAMPLE_BITS
) (
  input  wire logic                                         clk,
  input  wire logic                                         rst_n,
  // input stream
  input  wire logic                                         in_tvalid,
  output logic                                              in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]             in_tdata,  // sample_value
  input  wire logic                                         in_tuser,  // series_start
  // result stream
  output logic                                              out_tvalid,
  input  wire logic                                         out_tready,
  output logic [((SAMPLE_BITS+MAX_ORDER+7)/8)*8-1:0]        out_tdata, // difference_value
  // configuration writes
  input  wire logic                                         cfg_we,
  input  wire logic [CFG_ADDR_W-1:0]                        cfg_addr,
  input  wire logic [CFG_DATA_W-1:0]                        cfg_wdata
);

`include "lagged_difference_filter_defines.svh"

  localparam int OUT_BITS    = SAMPLE_BITS + MAX_ORDER;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int POS_W       = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int LAG_W       = $clog2(MAX_LAG + 1);
  localparam int ORD_W       = $clog2(MAX_ORDER + 1);
  localparam int SEEN_LIMIT  = MAX_ORDER * MAX_LAG;
  localparam int SEEN_W      = $clog2(SEEN_LIMIT + 1);
  localparam int ROW_W       = MAX_ORDER * OUT_BITS;

  // configuration and series state
  logic [LAG_REG_W-1:0]   lag_r;
  logic [ORDER_REG_W-1:0] order_r;
  logic [POS_W-1:0]       ring_r;
  logic [SEEN_W-1:0]      seen_r;

  // compute stage
  logic                          s1_valid_r;
  logic                          s1_emit_r;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [POS_W-1:0]              s1_pos_r;
  logic                          fwd_hit_r;
  logic [ROW_W-1:0]              fwd_row_r;

  // output register
  logic                out_valid_r;
  logic [OUT_BITS-1:0] out_data_r;

  logic [LAG_W-1:0]       lag_eff;
  logic [ORD_W-1:0]       ord_eff;
  logic [ORD_W+LAG_W-1:0] need_cnt;
  logic                   in_acc;
  logic [SEEN_W-1:0]      seen0;
  logic [POS_W-1:0]       ring0;
  logic [POS_W-1:0]       pos0;
  logic [LAG_W-1:0]       pos_inc;
  logic [POS_W-1:0]       ring_nxt;
  logic [SEEN_W-1:0]      seen_nxt;
  logic                   emit0;
  logic                   out_free;
  logic                   s1_adv;
  logic [ROW_W-1:0]       ram_rdata;
  logic [ROW_W-1:0]       old_row;
  logic [ROW_W-1:0]       new_row;
  logic [OUT_BITS-1:0]    cur [0:MAX_ORDER];

  // out-of-range lag and order clamp to the supported span
  assign lag_eff = (lag_r == '0) ? LAG_W'(1)
                 : ((32'(lag_r) > MAX_LAG) ? LAG_W'(MAX_LAG) : LAG_W'(lag_r));
  assign ord_eff = (32'(order_r) > MAX_ORDER) ? ORD_W'(MAX_ORDER) : ORD_W'(order_r);
  assign need_cnt = (ORD_W+LAG_W)'(ord_eff) * (ORD_W+LAG_W)'(lag_eff);

  assign out_free  = !out_valid_r || out_tready;
  assign s1_adv    = s1_valid_r && (!s1_emit_r || out_free);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    seen0    = in_tuser ? '0 : seen_r;
    ring0    = in_tuser ? '0 : ring_r;
    pos0     = (32'(ring0) >= 32'(lag_eff)) ? '0 : ring0;
    pos_inc  = LAG_W'(pos0) + LAG_W'(1);
    ring_nxt = (pos_inc >= lag_eff) ? '0 : POS_W'(pos_inc);
    seen_nxt = (32'(seen0) < SEEN_LIMIT) ? seen0 + SEEN_W'(1) : seen0;
    emit0    = 32'(seen0) >= 32'(need_cnt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lag_r   <= LAG_REG_W'(1);
      order_r <= ORDER_REG_W'(1);
      ring_r  <= '0;
      seen_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_LAG_DISTANCE: begin
          lag_r  <= cfg_wdata[LAG_REG_W-1:0];
          ring_r <= '0;
          seen_r <= '0;
        end
        CFG_DIFFERENCE_ORDER: begin
          order_r <= cfg_wdata[ORDER_REG_W-1:0];
          ring_r  <= '0;
          seen_r  <= '0;
        end
        default: begin
        end
      endcase
    end else if (in_acc) begin
      ring_r <= ring_nxt;
      seen_r <= seen_nxt;
    end
  end

  ldf_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_LAG)
  ) u_hist_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_pos_r),
    .wdata (new_row),
    .re    (in_acc),
    .raddr (pos0),
    .rdata (ram_rdata)
  );

  // row written on the edge that read it comes from the bypass register
  assign old_row = fwd_hit_r ? fwd_row_r : ram_rdata;

  always_comb begin
    cur[0] = OUT_BITS'(s1_sample_r);
    for (int k = 0; k < MAX_ORDER; k++) begin
      new_row[k*OUT_BITS +: OUT_BITS] = cur[k];
      cur[k+1] = cur[k] - old_row[k*OUT_BITS +: OUT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s1_emit_r   <= 1'b0;
      fwd_hit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
        s1_emit_r  <= emit0;
        fwd_hit_r  <= s1_adv && (s1_pos_r == pos0);
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
        fwd_hit_r  <= 1'b0;
      end
      if (s1_adv && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_tdata[SAMPLE_BITS-1:0];
      s1_pos_r    <= pos0;
      fwd_row_r   <= new_row;
    end
    if (s1_adv && s1_emit_r) begin
      out_data_r <= cur[ord_eff];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  `LDF_ASSERT_IMP(a_fwd_needs_item, fwd_hit_r, s1_valid_r, "bypass set with empty stage")
  `LDF_ASSERT_IMP(a_ring_in_lag, 1'b1, 32'(ring_r) < 32'(lag_eff), "ring position beyond lag")
  `LDF_ASSERT_IMP(a_seen_sat, 1'b1, 32'(seen_r) <= SEEN_LIMIT, "sample count past limit")
  `LDF_ASSERT_NXT(a_result_lands, s1_adv && s1_emit_r, out_tvalid, "result lost at output")

endmodule

`default_nettype wire

[tb/lagged_difference_checker.sv]
// result checker for the lagged difference filter: predicts every difference and compares
`timescale 1ns / 100ps

module lagged_difference_checker
  import ldf_pkg::*;
(
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               in_tvalid,
  input  logic                                               in_tready,
  input  logic [((LDF_SAMPLE_BITS+7)/8)*8-1:0]               in_tdata,  // sample_value
  input  logic                                               in_tuser,  // series_start
  input  logic                                               out_tvalid,
  input  logic                                               out_tready,
  input  logic [((LDF_SAMPLE_BITS+LDF_MAX_ORDER+7)/8)*8-1:0] out_tdata, // difference_value
  input  logic                                               cfg_we,
  input  logic [CFG_ADDR_W-1:0]                              cfg_addr,
  input  logic [CFG_DATA_W-1:0]                              cfg_wdata,
  output int                                                 fail_count,
  output int                                                 pending_results
);

  localparam int OUT_BITS = LDF_SAMPLE_BITS + LDF_MAX_ORDER;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  // one delay line per stage, holding that stage's input
  logic signed [OUT_BITS-1:0] delay_line [LDF_MAX_ORDER][LDF_MAX_LAG];
  int unsigned                write_slot;
  int unsigned                series_count;
  logic [LAG_REG_W-1:0]       lag_setting;
  logic [ORDER_REG_W-1:0]     order_setting;

  logic signed [OUT_BITS-1:0] expected_differences [$];
  logic signed [OUT_BITS-1:0] seen_difference;
  logic signed [OUT_BITS-1:0] wanted_difference;

  initial begin
    fail_count      = 0;
    pending_results = 0;
  end

  task automatic report_mismatch(input string what, input logic signed [OUT_BITS-1:0] got,
                                 input logic signed [OUT_BITS-1:0] want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic apply_register_write(input logic [CFG_ADDR_W-1:0] addr,
                                      input logic [CFG_DATA_W-1:0] data);
    case (addr)
      CFG_LAG_DISTANCE: begin
        lag_setting  = data[LAG_REG_W-1:0];
        series_count = 0;
        write_slot   = 0;
      end
      CFG_DIFFERENCE_ORDER: begin
        order_setting = data[ORDER_REG_W-1:0];
        series_count  = 0;
        write_slot    = 0;
      end
      default: ;  // unknown index: no effect at all
    endcase
  endtask

  task automatic predict_difference(input logic signed [LDF_SAMPLE_BITS-1:0] sample,
                                    input logic new_series);
    int unsigned lag;
    int unsigned order;
    int unsigned slot;
    int unsigned k;
    longint      acc;
    longint      prior;
    bit          warmed_up;
    lag = (lag_setting == 0) ? 1 :
          (lag_setting > LDF_MAX_LAG) ? LDF_MAX_LAG : lag_setting;
    order = (order_setting > LDF_MAX_ORDER) ? LDF_MAX_ORDER : order_setting;
    if (new_series) begin
      series_count = 0;
      write_slot   = 0;
    end
    if (write_slot >= lag) write_slot = 0;
    slot = write_slot;
    acc  = sample;
    for (k = 0; k < order; k++) begin
      prior = delay_line[k][slot];
      delay_line[k][slot] = acc[OUT_BITS-1:0];
      acc = acc - prior;
    end
    warmed_up  = (series_count >= order * lag);
    write_slot = (slot + 1 >= lag) ? 0 : slot + 1;
    if (series_count < LDF_MAX_ORDER * LDF_MAX_LAG) series_count++;
    if (warmed_up) expected_differences.push_back(acc[OUT_BITS-1:0]);
  endtask

  always @(posedge clk) begin : watch
    int k;
    int i;
    if (!rst_n) begin
      for (k = 0; k < LDF_MAX_ORDER; k++)
        for (i = 0; i < LDF_MAX_LAG; i++)
          delay_line[k][i] = '0;
      write_slot    = 0;
      series_count  = 0;
      lag_setting   = LAG_REG_W'(1);
      order_setting = ORDER_REG_W'(1);
      expected_differences.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        seen_difference = out_tdata[OUT_BITS-1:0];
        if (expected_differences.size() == 0) begin
          report_mismatch("unexpected difference_value", seen_difference, '0);
        end else begin
          wanted_difference = expected_differences.pop_front();
          if (seen_difference !== wanted_difference)
            report_mismatch("difference_value", seen_difference, wanted_difference);
        end
        if (out_tdata[OUT_W-1:OUT_BITS] !== '0)
          report_mismatch("tdata padding", OUT_BITS'(out_tdata[OUT_W-1:OUT_BITS]), '0);
      end
      if (cfg_we) apply_register_write(cfg_addr, cfg_wdata);
      if (in_tvalid && in_tready)
        predict_difference(in_tdata[LDF_SAMPLE_BITS-1:0], in_tuser);
    end
    pending_results = expected_differences.size();
  end

endmodule

[tb/tb_lagged_difference_filter.sv]
// testbench top for the lagged difference filter: stimulus, stalls and verdict
`timescale 1ns / 100ps

module tb_lagged_difference_filter;
  import ldf_pkg::*;

  localparam int IN_W         = ((LDF_SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W        = ((LDF_SAMPLE_BITS + LDF_MAX_ORDER + 7) / 8) * 8;
  localparam int ITEM_TARGET  = 550;
  localparam int QUIET_ITEMS  = 80;
  localparam int HOLD_CYCLES  = 48;
  localparam int LIMIT_CYCLES = 200000;

  // indexes with no register behind them
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_2 = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED_3 = 2'd3;

  localparam logic [15:0] SAMPLE_MAX = 16'h7fff;
  localparam logic [15:0] SAMPLE_MIN = 16'h8000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata;   // sample_value
  logic                  in_tuser;   // series_start
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_W-1:0]      out_tdata;  // difference_value
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int fail_count;
  int pending_results;
  int items_sent;
  bit idle_on;
  bit hold_request;

  lagged_difference_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  lagged_difference_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // receiver side: random stalls, plus one long hold on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
        out_tready   = 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 8) - 1) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        if (idle_on) repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  function automatic logic [15:0] random_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return 16'($urandom_range(0, 16)) - 16'd8;
      default: return 16'($urandom);
    endcase
  endfunction

  // called and returns at a falling edge; tvalid stays high for a following sample
  task automatic put_sample(input logic [15:0] value, input logic first);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = value;
    in_tuser  = first;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  // stop sending until every expected difference is back, then let the pipe go quiet
  task automatic settle();
    in_tvalid = 1'b0;
    in_tuser  = 1'b0;
    while (pending_results != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic send_series(input int len, input logic first_flag);
    int  n;
    logic flag;
    for (n = 0; n < len; n++) begin
      // a stray restart now and then breaks the series
      flag = (n == 0) ? first_flag : ($urandom_range(0, 31) == 0);
      put_sample(random_sample(), flag);
    end
  endtask

  task automatic random_phase(input int idx);
    int unsigned lag_data;
    int unsigned order_data;
    int unsigned lag_eff;
    int unsigned order_eff;
    int unsigned warm_up;
    int          series;
    int          s;
    int          len;
    case (idx)
      0: begin
        lag_data   = LDF_MAX_LAG;
        order_data = LDF_MAX_ORDER;
      end
      1: begin
        lag_data   = 31;
        order_data = 7;
      end
      default: begin
        lag_data   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 5);
        order_data = $urandom_range(0, 7);
      end
    endcase
    lag_eff   = (lag_data == 0) ? 1 : (lag_data > LDF_MAX_LAG) ? LDF_MAX_LAG : lag_data;
    order_eff = (order_data > LDF_MAX_ORDER) ? LDF_MAX_ORDER : order_data;
    warm_up   = lag_eff * order_eff;
    // upper bits of the order write are don't-care
    order_data = order_data | ($urandom_range(0, 3) << ORDER_REG_W);
    if ($urandom_range(0, 1)) begin
      write_reg(CFG_LAG_DISTANCE, CFG_DATA_W'(lag_data));
      write_reg(CFG_DIFFERENCE_ORDER, CFG_DATA_W'(order_data));
    end else begin
      write_reg(CFG_DIFFERENCE_ORDER, CFG_DATA_W'(order_data));
      write_reg(CFG_LAG_DISTANCE, CFG_DATA_W'(lag_data));
    end
    series = (warm_up > 16) ? 1 : $urandom_range(2, 4);
    for (s = 0; s < series; s++) begin
      if ($urandom_range(0, 5) == 0)
        len = $urandom_range(1, (warm_up > 0) ? warm_up : 1);
      else
        len = warm_up + $urandom_range(1, 12);
      send_series(len, (s == 0) ? 1'($urandom_range(0, 1)) : 1'b1);
    end
    settle();
  endtask

  initial begin : stimulus
    int phase;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    cfg_we       = 1'b0;
    cfg_addr     = CFG_LAG_DISTANCE;
    cfg_wdata    = '0;
    items_sent   = 0;
    idle_on      = 1'b1;
    hold_request = 1'b0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: first difference, lag one, full-scale steps
    put_sample(SAMPLE_MAX, 1'b1);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(16'h0000, 1'b0);
    put_sample(16'hffff, 1'b0);
    put_sample(16'h0001, 1'b0);
    settle();

    // order zero passes samples straight through
    write_reg(CFG_DIFFERENCE_ORDER, CFG_DATA_W'(0));
    put_sample(SAMPLE_MAX, 1'b1);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(16'h5555, 1'b0);
    put_sample(16'haaaa, 1'b0);
    settle();

    // lag two, order two (upper data bit ignored); a short series then a restart
    write_reg(CFG_LAG_DISTANCE, CFG_DATA_W'(2));
    write_reg(CFG_DIFFERENCE_ORDER, 5'b01010);
    put_sample(16'd100, 1'b1);
    put_sample(-16'sd200, 1'b0);
    put_sample(16'd300, 1'b0);
    put_sample(SAMPLE_MAX, 1'b1);
    put_sample(SAMPLE_MAX, 1'b0);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(SAMPLE_MAX, 1'b0);
    put_sample(SAMPLE_MAX, 1'b0);
    settle();

    // writes to unknown indexes must not restart the series
    write_reg(CFG_UNUSED_2, 5'h1f);
    write_reg(CFG_UNUSED_3, 5'h15);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(SAMPLE_MAX, 1'b0);
    settle();

    // lag zero acts as one, order seven acts as four; alternating extremes hit the top
    write_reg(CFG_LAG_DISTANCE, CFG_DATA_W'(0));
    write_reg(CFG_DIFFERENCE_ORDER, 5'b11111);
    put_sample(SAMPLE_MAX, 1'b0);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(SAMPLE_MAX, 1'b0);
    put_sample(SAMPLE_MIN, 1'b0);
    put_sample(SAMPLE_MAX, 1'b0);
    put_sample(SAMPLE_MIN, 1'b0);
    settle();

    // receiver holds off while samples keep coming, so the input backs up
    write_reg(CFG_DIFFERENCE_ORDER, CFG_DATA_W'(0));
    hold_request = 1'b1;
    send_series(30, 1'b1);
    settle();

    phase = 0;
    while (items_sent < ITEM_TARGET - QUIET_ITEMS) begin
      random_phase(phase);
      phase++;
    end
    // last part runs at full rate
    idle_on = 1'b0;
    while (items_sent < ITEM_TARGET) begin
      random_phase(phase);
      phase++;
    end

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
